FILE: rtl/obm_pkg.sv
// Shared types and constants for the order book matcher.
package obm_pkg;

  localparam int MaxSide = 32;
  localparam int IdxW    = $clog2(MaxSide);
  localparam int CntW    = IdxW + 1;
  localparam int ValW    = 32;
  localparam int ResCap  = 63;
  localparam int ResW    = 6;

  localparam logic [1:0] SideAsk = 2'd0;
  localparam logic [1:0] SideBid = 2'd1;

  localparam logic CfgProduct = 1'b0;
  localparam logic CfgTime    = 1'b1;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SORT_BEGIN,
    S_SORT_CHK,
    S_SORT_SCAN,
    S_MATCH_BEGIN,
    S_ICHK,
    S_ALAT,
    S_JCHK,
    S_EVAL,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic sort_begin;
    logic scan_begin;
    logic scan_step;
    logic scan_commit;
    logic side;
    logic match_begin;
    logic ask_rd;
    logic ask_latch;
    logic i_inc;
    logic bid_rd;
    logic bid_eval;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic pos_end;
    logic i_end;
    logic j_end;
    logic brk;
    logic need_push;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/order_book_ask_bid_matcher.sv
// Order book matcher: filter, store, sort and match one round of orders.
// Orders that match the selected product and timestamp are stored at one transfer per
// cycle, up to 32 per side; further ones set the overflow flag. The transfer with tlast
// set stalls the input while both sides are selection-sorted into separate sorted stores
// (one memory read per cycle) and then matched by a walk over the sorted bids for each
// ask. Each trade, up to 63 per round, leaves as one output transfer; the last one
// carries tlast, and a round without trades yields a single no-sale result.
// The input is held off until the round's final result has been registered for output.
module order_book_ask_bid_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // product_id[7:0], time_id[23:8], price[55:24],
                                     // amount[87:56]
  input  logic [1:0]  s_axis_tuser,  // side[1:0]
  input  logic        s_axis_tlast,  // last_order
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // sale_price[31:0], sale_amount[63:32]
  output logic [1:0]  m_axis_tuser,  // no_sale[0], overflowed[1]
  output logic        m_axis_tlast,  // last_sale
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import obm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  obm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  obm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .product_id_i  (s_axis_tdata[7:0]),
    .time_id_i     (s_axis_tdata[23:8]),
    .side_i        (s_axis_tuser),
    .price_i       (s_axis_tdata[55:24]),
    .amount_i      (s_axis_tdata[87:56]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .sale_price_o  (m_axis_tdata[31:0]),
    .sale_amount_o (m_axis_tdata[63:32]),
    .no_sale_o     (m_axis_tuser[0]),
    .overflowed_o  (m_axis_tuser[1]),
    .last_sale_o   (m_axis_tlast)
  );

endmodule

FILE: rtl/obm_ctrl.sv
// Sequencer for loading, sorting and matching one order book round.
module obm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  input  obm_pkg::sts_t sts_i,
  output obm_pkg::cmd_t cmd_o
);
  import obm_pkg::*;

  state_e state_q, state_d;
  logic   side_q, side_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    side_d  = side_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i && in_last_i) begin
          state_d = S_SORT_BEGIN;
          side_d  = 1'b0;
        end
      end
      S_SORT_BEGIN: state_d = S_SORT_CHK;
      S_SORT_CHK: begin
        if (sts_i.pos_end) begin
          if (!side_q) begin
            side_d  = 1'b1;
            state_d = S_SORT_BEGIN;
          end else begin
            state_d = S_MATCH_BEGIN;
          end
        end else begin
          state_d = S_SORT_SCAN;
        end
      end
      S_SORT_SCAN: begin
        if (sts_i.scan_end) state_d = S_SORT_CHK;
      end
      S_MATCH_BEGIN: state_d = S_ICHK;
      S_ICHK: state_d = sts_i.i_end ? S_FINISH : S_ALAT;
      S_ALAT: state_d = S_JCHK;
      S_JCHK: state_d = sts_i.j_end ? S_ICHK : S_EVAL;
      S_EVAL: begin
        if (!(sts_i.need_push && !sts_i.out_free)) begin
          state_d = sts_i.brk ? S_ICHK : S_JCHK;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) state_d = S_LOAD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.side = side_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SORT_BEGIN:  cmd_o.sort_begin = 1'b1;
      S_SORT_CHK:    cmd_o.scan_begin = !sts_i.pos_end;
      S_SORT_SCAN: begin
        cmd_o.scan_commit = sts_i.scan_end;
        cmd_o.scan_step   = !sts_i.scan_end;
      end
      S_MATCH_BEGIN: cmd_o.match_begin = 1'b1;
      S_ICHK:        cmd_o.ask_rd = !sts_i.i_end;
      S_ALAT:        cmd_o.ask_latch = 1'b1;
      S_JCHK: begin
        cmd_o.i_inc  = sts_i.j_end;
        cmd_o.bid_rd = !sts_i.j_end;
      end
      S_EVAL:   cmd_o.bid_eval = !(sts_i.need_push && !sts_i.out_free);
      S_FINISH: cmd_o.finish = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

FILE: rtl/obm_dp.sv
// Order stores, selection sort, match arithmetic and result register.
module obm_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  obm_pkg::cmd_t            cmd_i,
  output obm_pkg::sts_t            sts_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [15:0]              cfg_data_i,
  input  logic [7:0]               product_id_i,
  input  logic [15:0]              time_id_i,
  input  logic [1:0]               side_i,
  input  logic [obm_pkg::ValW-1:0] price_i,
  input  logic [obm_pkg::ValW-1:0] amount_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [obm_pkg::ValW-1:0] sale_price_o,
  output logic [obm_pkg::ValW-1:0] sale_amount_o,
  output logic                     no_sale_o,
  output logic                     overflowed_o,
  output logic                     last_sale_o
);
  import obm_pkg::*;

  logic [7:0]  product_sel_q;
  logic [15:0] time_sel_q;

  logic [ValW-1:0] ask_p_mem [MaxSide];
  logic [ValW-1:0] ask_a_mem [MaxSide];
  logic [ValW-1:0] bid_p_mem [MaxSide];
  logic [ValW-1:0] bid_a_mem [MaxSide];
  logic [ValW-1:0] sa_p_mem  [MaxSide];
  logic [ValW-1:0] sa_a_mem  [MaxSide];
  logic [ValW-1:0] sb_p_mem  [MaxSide];
  logic [ValW-1:0] sb_a_mem  [MaxSide];

  logic [CntW-1:0] ask_cnt_q, bid_cnt_q, k_q, pos_q, i_q, j_q;
  logic            ovf_q;
  logic [MaxSide-1:0] used_q;
  logic            rd_vld_q, found_q;
  logic [IdxW-1:0] rd_idx_q, best_idx_q;
  logic [ValW-1:0] rd_ap_q, rd_aa_q, rd_bp_q, rd_ba_q;
  logic [ValW-1:0] best_p_q, best_a_q;
  logic [ValW-1:0] sa_p_rd_q, sa_a_rd_q, sb_p_rd_q, sb_a_rd_q;
  logic [ValW-1:0] cur_ap_q, cur_aa_q;
  logic            pend_vld_q;
  logic [ValW-1:0] pend_p_q, pend_a_q;
  logic [ResW-1:0] res_cnt_q;

  logic            qualify, ask_we, bid_we;
  logic [CntW-1:0] n_side;
  logic [ValW-1:0] cand_p, cand_a;
  logic            better;
  logic            sale, brk, sale_take, push;
  logic [ValW-1:0] sale_a, aa_new, ba_new;
  logic            sb_we;
  logic [IdxW-1:0] sb_waddr;
  logic [ValW-1:0] sb_a_wdata;

  assign qualify = (product_id_i == product_sel_q) && (time_id_i == time_sel_q)
                   && ((side_i == SideAsk) || (side_i == SideBid));
  assign ask_we  = cmd_i.load && qualify && (side_i == SideAsk)
                   && (ask_cnt_q < CntW'(MaxSide));
  assign bid_we  = cmd_i.load && qualify && (side_i == SideBid)
                   && (bid_cnt_q < CntW'(MaxSide));

  assign n_side = cmd_i.side ? bid_cnt_q : ask_cnt_q;
  assign cand_p = cmd_i.side ? rd_bp_q : rd_ap_q;
  assign cand_a = cmd_i.side ? rd_ba_q : rd_aa_q;
  // strict compare keeps the earliest arrival on equal prices
  assign better = rd_vld_q && !used_q[rd_idx_q] &&
                  (!found_q || (cmd_i.side ? (cand_p > best_p_q) : (cand_p < best_p_q)));

  // one bid step of the match walk
  always_comb begin
    sale   = 1'b0;
    brk    = 1'b0;
    sale_a = cur_aa_q;
    aa_new = cur_aa_q;
    ba_new = sb_a_rd_q;
    if (sb_p_rd_q < cur_ap_q) begin
      sale = 1'b0;
    end else if (sb_a_rd_q == cur_aa_q) begin
      sale   = 1'b1;
      brk    = 1'b1;
      ba_new = '0;
    end else if (sb_a_rd_q > cur_aa_q) begin
      sale   = 1'b1;
      brk    = 1'b1;
      ba_new = sb_a_rd_q - cur_aa_q;
    end else if (sb_a_rd_q != '0) begin
      sale   = 1'b1;
      sale_a = sb_a_rd_q;
      aa_new = cur_aa_q - sb_a_rd_q;
      ba_new = '0;
    end
  end

  assign sale_take = sale && (res_cnt_q < ResW'(ResCap));
  assign push      = (cmd_i.bid_eval && sale_take && pend_vld_q) || cmd_i.finish;

  assign sts_o.scan_end  = (k_q == n_side) && !rd_vld_q;
  assign sts_o.pos_end   = (pos_q == n_side);
  assign sts_o.i_end     = (i_q == ask_cnt_q);
  assign sts_o.j_end     = (j_q == bid_cnt_q);
  assign sts_o.brk       = brk;
  assign sts_o.need_push = sale_take && pend_vld_q;
  assign sts_o.out_free  = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      product_sel_q <= '0;
      time_sel_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgProduct: product_sel_q <= cfg_data_i[7:0];
        CfgTime:    time_sel_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // raw stores, filled in arrival order
  always_ff @(posedge clk_i) begin
    if (ask_we) begin
      ask_p_mem[ask_cnt_q[IdxW-1:0]] <= price_i;
      ask_a_mem[ask_cnt_q[IdxW-1:0]] <= amount_i;
    end
    if (bid_we) begin
      bid_p_mem[bid_cnt_q[IdxW-1:0]] <= price_i;
      bid_a_mem[bid_cnt_q[IdxW-1:0]] <= amount_i;
    end
    if (cmd_i.scan_step) begin
      rd_ap_q  <= ask_p_mem[k_q[IdxW-1:0]];
      rd_aa_q  <= ask_a_mem[k_q[IdxW-1:0]];
      rd_bp_q  <= bid_p_mem[k_q[IdxW-1:0]];
      rd_ba_q  <= bid_a_mem[k_q[IdxW-1:0]];
      rd_idx_q <= k_q[IdxW-1:0];
    end
  end

  // sorted ask store
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_commit && !cmd_i.side) begin
      sa_p_mem[pos_q[IdxW-1:0]] <= best_p_q;
      sa_a_mem[pos_q[IdxW-1:0]] <= best_a_q;
    end
    if (cmd_i.ask_rd) begin
      sa_p_rd_q <= sa_p_mem[i_q[IdxW-1:0]];
      sa_a_rd_q <= sa_a_mem[i_q[IdxW-1:0]];
    end
  end

  // sorted bid store; amounts are rewritten while matching
  assign sb_we      = (cmd_i.scan_commit && cmd_i.side) || cmd_i.bid_eval;
  assign sb_waddr   = cmd_i.bid_eval ? j_q[IdxW-1:0] : pos_q[IdxW-1:0];
  assign sb_a_wdata = cmd_i.bid_eval ? ba_new : best_a_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_commit && cmd_i.side) sb_p_mem[pos_q[IdxW-1:0]] <= best_p_q;
    if (sb_we) sb_a_mem[sb_waddr] <= sb_a_wdata;
    if (cmd_i.bid_rd) begin
      sb_p_rd_q <= sb_p_mem[j_q[IdxW-1:0]];
      sb_a_rd_q <= sb_a_mem[j_q[IdxW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && better) begin
      best_p_q   <= cand_p;
      best_a_q   <= cand_a;
      best_idx_q <= rd_idx_q;
    end
    if (cmd_i.ask_latch) begin
      cur_ap_q <= sa_p_rd_q;
      cur_aa_q <= sa_a_rd_q;
    end else if (cmd_i.bid_eval) begin
      cur_aa_q <= aa_new;
    end
    if (cmd_i.bid_eval && sale_take) begin
      pend_p_q <= cur_ap_q;
      pend_a_q <= sale_a;
    end
    if (push) begin
      sale_price_o  <= cmd_i.finish && !pend_vld_q ? '0 : pend_p_q;
      sale_amount_o <= cmd_i.finish && !pend_vld_q ? '0 : pend_a_q;
      no_sale_o     <= cmd_i.finish && !pend_vld_q;
      overflowed_o  <= ovf_q;
      last_sale_o   <= cmd_i.finish;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ask_cnt_q   <= '0;
      bid_cnt_q   <= '0;
      ovf_q       <= 1'b0;
      k_q         <= '0;
      pos_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      used_q      <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      pend_vld_q  <= 1'b0;
      res_cnt_q   <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (ask_we) ask_cnt_q <= ask_cnt_q + 1'b1;
      if (bid_we) bid_cnt_q <= bid_cnt_q + 1'b1;
      if (cmd_i.load && qualify && !ask_we && !bid_we) ovf_q <= 1'b1;

      if (cmd_i.sort_begin) begin
        pos_q  <= '0;
        used_q <= '0;
      end
      if (cmd_i.scan_begin) begin
        k_q      <= '0;
        found_q  <= 1'b0;
        rd_vld_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        rd_vld_q <= (k_q < n_side);
        if (k_q < n_side) k_q <= k_q + 1'b1;
        if (better) found_q <= 1'b1;
      end
      if (cmd_i.scan_commit) begin
        used_q[best_idx_q] <= 1'b1;
        pos_q <= pos_q + 1'b1;
      end

      if (cmd_i.match_begin) i_q <= '0;
      if (cmd_i.i_inc || (cmd_i.bid_eval && brk)) i_q <= i_q + 1'b1;
      if (cmd_i.ask_latch) j_q <= '0;
      if (cmd_i.bid_eval && !brk) j_q <= j_q + 1'b1;

      if (cmd_i.bid_eval && sale_take) begin
        pend_vld_q <= 1'b1;
        res_cnt_q  <= res_cnt_q + 1'b1;
      end

      if (push) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end

      if (cmd_i.finish) begin
        ask_cnt_q  <= '0;
        bid_cnt_q  <= '0;
        ovf_q      <= 1'b0;
        pend_vld_q <= 1'b0;
        res_cnt_q  <= '0;
      end
    end
  end

endmodule
